// ----- sv/sv39_page_table_walker_assert.svh -----
// Assertion macros shared by the checker of the Sv39 page table walker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef SV39_PAGE_TABLE_WALKER_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SV39_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SV39_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sv39ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Types and constants shared by the Sv39 page table walker modules.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

    // Fixed Sv39 geometry.
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int LEVELS            = 3;
    localparam int ENTRY_W           = 9;
    localparam int PPN_W             = 44;
    localparam int VA_W              = 39;
    localparam int PA_W              = 56;
    localparam int FLAG_W            = 10;
    localparam int PTE_W             = 64;
    localparam int STATUS_W          = 3;
    localparam int CFG_DATA_W        = 44;
    localparam int CFG_INDEX_W       = 2;
    localparam int ROOT_W            = 3;
    localparam int LIMIT_W           = 40;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_PAGE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_BASE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_VA    = 2'd2;

    // Reset value of the virtual address limit (2^38).
    localparam logic [LIMIT_W-1:0] LIMIT_VA_RESET = 40'h40_0000_0000;

    // Input actions.
    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VA_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USER   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PERM       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 3'd5;

    // PTE flag bit positions.
    localparam int PTE_V   = 0;
    localparam int PTE_R   = 1;
    localparam int PTE_X   = 3;
    localparam int PTE_U   = 4;
    localparam int PTE_PPN_LSB = 10;

    // Outcome of checking one PTE.
    typedef struct packed {
        logic                fault;
        logic [STATUS_W-1:0] code;
    } check_t;

    // One result transaction.
    typedef struct packed {
        logic [PA_W-1:0]     page_address;
        logic [FLAG_W-1:0]   leaf_flags;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Walk sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_L2   = 5'b00010,
        S_L1   = 5'b00100,
        S_L0   = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

endpackage

// ----- sv/sv39ptw_ram.sv -----
// ----------------------------------------------------------------------------
// sv39ptw_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sv39ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sv39ptw_pte_check.sv -----
// ----------------------------------------------------------------------------
// sv39ptw_pte_check
// Checks one PTE read from the store, either as a pointer to the next table
// or as the leaf, and maps a pointer's PPN to a store page.
// ----------------------------------------------------------------------------
module sv39ptw_pte_check
    import sv39ptw_pkg::*;
#(
    parameter int TABLE_PAGES = 8,
    parameter int PAGE_W      = 3
) (
    input  logic [PTE_W-1:0]  pte,
    input  logic [PPN_W-1:0]  table_base_ppn,
    input  logic              is_leaf,
    input  logic [2:0]        required_perm,
    input  logic              require_user,
    output check_t            check,
    output logic [PAGE_W-1:0] next_page
);

    logic [PPN_W-1:0] ppn;
    logic [PPN_W:0]   diff;
    logic             outside;

    // Pointer PPN relative to the store base; borrow means below the base.
    assign ppn     = pte[PTE_PPN_LSB +: PPN_W];
    assign diff    = {1'b0, ppn} - {1'b0, table_base_ppn};
    assign outside = diff[PPN_W] || (diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));
    assign next_page = diff[PAGE_W-1:0];

    // Pointer checks at the upper levels, leaf checks at level zero.
    always_comb
    begin
        check.fault = 1'b0;
        check.code  = ST_OK;
        if (!pte[PTE_V])
        begin
            check.fault = 1'b1;
            check.code  = ST_INVALID;
        end
        else if (!is_leaf)
        begin
            if (outside)
            begin
                check.fault = 1'b1;
                check.code  = ST_OUTSIDE;
            end
        end
        else if (require_user && !pte[PTE_U])
        begin
            check.fault = 1'b1;
            check.code  = ST_NOT_USER;
        end
        else if ((pte[PTE_X:PTE_R] & required_perm) != required_perm)
        begin
            check.fault = 1'b1;
            check.code  = ST_PERM;
        end
    end

endmodule

// ----- sv/sv39ptw_out.sv -----
// ----------------------------------------------------------------------------
// sv39ptw_out
// Output register for result transactions, decoupling the walker from a
// stalled receiver.
// ----------------------------------------------------------------------------
module sv39ptw_out
    import sv39ptw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  result_t             result,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PA_W-1:0]     page_address,
    output logic [FLAG_W-1:0]   leaf_flags,
    output logic [STATUS_W-1:0] status
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    // The register can take a result when empty or when it drains this cycle.
    assign ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload holds while stalled.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_address = out_reg.page_address;
    assign leaf_flags   = out_reg.leaf_flags;
    assign status       = out_reg.status;

endmodule

// ----- sv/sv39_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Three-level Sv39 page table walker over a local PTE store.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   action, word_index, word_data,
//                                  virtual_address, required_perm, require_user
//   out      out_valid / out_stall page_address, leaf_flags, status
//   cfg      cfg_we                cfg_index, cfg_wdata
//
// A translation reaching the leaf makes three dependent store reads, then
// loads the output register and returns to idle before the next acceptance.
// A fault at level 2 or 1 ends the walk after that level's read; a write, or
// a translation that faults before the first read, skips to the final state.
// The store has no reset and needs no clearing pass. A stalled output holds the
// walker in its final state, and so stalls the input, until the register frees.
// ----------------------------------------------------------------------------
module sv39_page_table_walker
    import sv39ptw_pkg::*;
#(
    parameter int TABLE_PAGES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [11:0]            word_index,
    input  logic [PTE_W-1:0]       word_data,
    input  logic [VA_W-1:0]        virtual_address,
    input  logic [2:0]             required_perm,
    input  logic                   require_user,
    // Output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PA_W-1:0]        page_address,
    output logic [FLAG_W-1:0]      leaf_flags,
    output logic [STATUS_W-1:0]    status
);

    localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int HOLD_W      = 2 * ENTRY_W;

    // Configuration registers.
    logic [ROOT_W-1:0]  root_page_reg;
    logic [PPN_W-1:0]   table_base_reg;
    logic [LIMIT_W-1:0] limit_va_reg;

    // Walk state.
    state_t             state_reg, state_next;
    logic [HOLD_W-1:0]  va_hold_reg, va_hold_next;
    logic [2:0]         perm_reg, perm_next;
    logic               user_reg, user_next;
    result_t            pend_reg, pend_next;

    // Store ports.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [PTE_W-1:0]   ram_rdata;

    // Check unit and output stage.
    check_t             check;
    logic [PAGE_W-1:0]  next_page;
    logic               out_load;
    logic               out_ready;

    logic               accept;
    logic               va_too_large;
    logic               root_outside;
    logic               widx_in_range;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_page_reg  <= '0;
            table_base_reg <= '0;
            limit_va_reg   <= LIMIT_VA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROOT_PAGE:  root_page_reg  <= cfg_wdata[ROOT_W-1:0];
                CFG_TABLE_BASE: table_base_reg <= cfg_wdata[PPN_W-1:0];
                CFG_LIMIT_VA:   limit_va_reg   <= cfg_wdata[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Acceptance and checks done before the first store read.
    assign in_stall      = (state_reg != S_IDLE);
    assign accept        = in_valid && !in_stall;
    assign va_too_large  = ({1'b0, virtual_address} >= limit_va_reg);
    assign root_outside  = (7'(root_page_reg) >= 7'(TABLE_PAGES));
    assign widx_in_range = (17'(word_index) < 17'(STORE_WORDS));
    assign ram_waddr     = ADDR_W'(word_index);

    // Walk sequencer: each level reads the store, the next cycle checks the
    // returned PTE and issues the read for the level below. Writes only occur
    // while idle, so a read never overlaps a write to the same entry.
    always_comb
    begin
        state_next   = state_reg;
        va_hold_next = va_hold_reg;
        perm_next    = perm_reg;
        user_next    = user_reg;
        pend_next    = pend_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = ADDR_W'({PAGE_W'(root_page_reg),
                                virtual_address[VA_W-1 -: ENTRY_W]});
        out_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    va_hold_next = virtual_address[VA_W-ENTRY_W-1 -: HOLD_W];
                    perm_next    = required_perm;
                    user_next    = require_user;
                    pend_next    = '0;
                    state_next   = S_DONE;
                    if (action == ACT_WRITE)
                    begin
                        ram_we = widx_in_range;
                    end
                    else if (va_too_large)
                    begin
                        pend_next.status = ST_VA_RANGE;
                    end
                    else if (root_outside)
                    begin
                        pend_next.status = ST_OUTSIDE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_L2;
                    end
                end
            end
            S_L2, S_L1:
            begin
                if (check.fault)
                begin
                    pend_next        = '0;
                    pend_next.status = check.code;
                    state_next       = S_DONE;
                end
                else
                begin
                    ram_re = 1'b1;
                    if (state_reg == S_L2)
                    begin
                        ram_raddr  = ADDR_W'({next_page,
                                              va_hold_reg[HOLD_W-1 -: ENTRY_W]});
                        state_next = S_L1;
                    end
                    else
                    begin
                        ram_raddr  = ADDR_W'({next_page, va_hold_reg[ENTRY_W-1:0]});
                        state_next = S_L0;
                    end
                end
            end
            S_L0:
            begin
                pend_next.leaf_flags   = ram_rdata[FLAG_W-1:0];
                pend_next.status       = check.code;
                pend_next.page_address = check.fault ? '0 :
                    {ram_rdata[PTE_PPN_LSB +: PPN_W], 12'd0};
                state_next             = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request and pending result registers.
    always_ff @(posedge clk)
    begin
        va_hold_reg <= va_hold_next;
        perm_reg    <= perm_next;
        user_reg    <= user_next;
        pend_reg    <= pend_next;
    end

    // PTE store.
    sv39ptw_ram #(
        .WIDTH (PTE_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // PTE check for the level that the returned word belongs to.
    sv39ptw_pte_check #(
        .TABLE_PAGES (TABLE_PAGES),
        .PAGE_W      (PAGE_W)
    ) u_check (
        .pte            (ram_rdata),
        .table_base_ppn (table_base_reg),
        .is_leaf        (state_reg == S_L0),
        .required_perm  (perm_reg),
        .require_user   (user_reg),
        .check          (check),
        .next_page      (next_page)
    );

    // Output register.
    sv39ptw_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .result       (pend_reg),
        .ready        (out_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .page_address (page_address),
        .leaf_flags   (leaf_flags),
        .status       (status)
    );

endmodule

// ----- sv/sv39ptw_checker.sv -----
// ----------------------------------------------------------------------------
// sv39ptw_checker
// Port-level assertions for the Sv39 page table walker, bound to the top.
// ----------------------------------------------------------------------------
`include "sv39_page_table_walker_assert.svh"

module sv39ptw_checker
    import sv39ptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   action,
    input  logic [11:0]            word_index,
    input  logic [PTE_W-1:0]       word_data,
    input  logic [VA_W-1:0]        virtual_address,
    input  logic [2:0]             required_perm,
    input  logic                   require_user,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [PA_W-1:0]        page_address,
    input  logic [FLAG_W-1:0]      leaf_flags,
    input  logic [STATUS_W-1:0]    status
);

    // A stalled result transaction stays offered.
    `SV39_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `SV39_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(page_address) && $stable(status), "result changed while stalled")

    // One transaction at a time: an accepted input stalls the next cycle.
    `SV39_ASSERT_NEXT(a_one_at_time, clk, rst_n, in_valid && !in_stall, in_stall, "input accepted while busy")

    // Any fault reports a zero page address.
    `SV39_ASSERT_SAME(a_fault_zero, clk, rst_n, out_valid && (status != ST_OK), page_address == '0, "fault with nonzero address")

    // Range and outside faults, found before the leaf, report no leaf flags.
    `SV39_ASSERT_SAME(a_early_flags, clk, rst_n, out_valid && (status == ST_VA_RANGE || status == ST_OUTSIDE), leaf_flags == '0, "flags on early fault")

endmodule

bind sv39_page_table_walker sv39ptw_checker u_checker (.*);
